// ===== src/teg_pkg.sv =====
// ----------------------------------------------------------------------------
// teg_pkg
// Types and constants shared by the touch event generator: item layouts,
// register indexes, reset values and divider sizing.
// ----------------------------------------------------------------------------
package teg_pkg;

  // Field widths fixed by the item layouts.
  localparam int RAW_W  = 12;
  localparam int REG_W  = 12;
  localparam int POS_W  = 12;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 3;

  // Divider sizing: product of a raw span and a display size.
  localparam int QUO_W     = 2 * RAW_W;
  localparam int REM_W     = RAW_W + 1;
  localparam int DIV_ITERS = QUO_W / 2;

  // Register reset values.
  localparam logic [REG_W-1:0] X_RAW_MIN_RST      = 12'd200;
  localparam logic [REG_W-1:0] X_RAW_MAX_RST      = 12'd3900;
  localparam logic [REG_W-1:0] Y_RAW_MIN_RST      = 12'd200;
  localparam logic [REG_W-1:0] Y_RAW_MAX_RST      = 12'd3900;
  localparam logic [REG_W-1:0] PIX_WIDTH_RST      = 12'd480;
  localparam logic [REG_W-1:0] PIX_HEIGHT_RST     = 12'd320;
  localparam logic [REG_W-1:0] MOVE_THRESHOLD_RST = 12'd5;

  // Register indexes on the configuration port.
  typedef enum logic [IDX_W-1:0] {
    REG_X_RAW_MIN      = 3'd0,
    REG_X_RAW_MAX      = 3'd1,
    REG_Y_RAW_MIN      = 3'd2,
    REG_Y_RAW_MAX      = 3'd3,
    REG_PIX_WIDTH      = 3'd4,
    REG_PIX_HEIGHT     = 3'd5,
    REG_MOVE_THRESHOLD = 3'd6
  } teg_reg_e;

  // One poll tick.
  typedef struct packed {
    logic              touched;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [TIME_W-1:0] time_ms;
  } teg_sample_t;

  // One touch event.
  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              pressed;
    logic [TIME_W-1:0] stamp;
  } teg_event_t;

  // Status of one axis lane.
  typedef struct packed {
    logic busy;
    logic done;
  } teg_lane_stat_t;

endpackage

// ===== src/teg_axis_lane.sv =====
// ----------------------------------------------------------------------------
// teg_axis_lane
// One axis of the coordinate mapper: clamps a raw sample to its calibrated
// window, multiplies by the display size and divides by the window span with
// a two-bit-per-cycle restoring divider, then saturates to the coordinate
// width, or gives zero when the window is empty.
// ----------------------------------------------------------------------------
module teg_axis_lane
  import teg_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RAW_W-1:0]      raw,
  input  logic [REG_W-1:0]      lo,
  input  logic [REG_W-1:0]      hi,
  input  logic [REG_W-1:0]      span,
  output teg_lane_stat_t        stat,
  output logic [COORD_BITS-1:0] coord
);

  localparam int CNT_W = $clog2(DIV_ITERS);
  localparam logic [QUO_W-1:0] CoordMax = QUO_W'((32'd1 << COORD_BITS) - 32'd1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_DONE
  } lane_state_t;

  lane_state_t       state;
  logic [RAW_W-1:0]  raw_q;
  logic              empty;
  logic [REG_W-1:0]  den;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;

  logic [RAW_W-1:0]  clamped;
  logic [RAW_W-1:0]  offset;
  logic [QUO_W-1:0]  product;
  logic [REM_W-1:0]  rem_next;
  logic [QUO_W-1:0]  quo_next;

  // Clamp into the raw window and scale by the display size.
  always_comb begin
    if (raw_q < lo) begin
      clamped = lo;
    end else if (raw_q > hi) begin
      clamped = hi;
    end else begin
      clamped = raw_q;
    end
    offset  = clamped - lo;
    product = QUO_W'(offset) * QUO_W'(span);
  end

  // Two restoring divide steps per cycle.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [QUO_W-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < 2; i++) begin
      r = {r[REM_W-2:0], q[QUO_W-1]};
      q = {q[QUO_W-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    rem_next = r;
    quo_next = q;
  end

  // Lane sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            raw_q <= raw;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          empty <= (hi <= lo);
          den   <= hi - lo;
          rem   <= '0;
          quo   <= product;
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_ITERS - 1)) begin
            state <= L_DONE;
            if (empty) begin
              coord <= '0;
            end else if (quo_next > CoordMax) begin
              coord <= CoordMax[COORD_BITS-1:0];
            end else begin
              coord <= quo_next[COORD_BITS-1:0];
            end
          end
        end
        L_DONE: begin
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign stat = '{busy: (state != L_IDLE), done: (state == L_DONE)};

endmodule

// ===== src/touch_event_generator_unit.sv =====
// ----------------------------------------------------------------------------
// touch_event_generator_unit
// Turns touch panel poll ticks into press, move and release events. A touched
// tick is mapped to display pixels by two axis lanes working side by side,
// each clamping, multiplying and dividing by the calibrated span; a merging
// stage then decides whether the new position is a fresh touch or moved
// beyond the threshold. The accepting edge starts the lanes, and a touched
// tick reaches the event register through the multiply, the radix-4 divider
// that each lane owns, a step in which the lanes hand their result to the
// merge, and the load of the event register, which waits until that register
// is free. The next tick is taken once the unit is back in idle; a touched
// tick that reports nothing goes back there without an event. An untouched
// tick holds the input only when it causes a release event, which is loaded
// through the emit state in the same way, once the register is free. A
// finished event waits in the output register while the next tick is already
// being processed; a new event waits for that register to be taken. Registers
// are written through the configuration port, which is always ready, and
// must only be written while the unit is idle.
// ----------------------------------------------------------------------------
module touch_event_generator_unit
  import teg_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  teg_sample_t      sample,
  output logic             evt_valid,
  input  logic             evt_stall,
  output teg_event_t       evt,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int CMP_W = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_EMIT
  } top_state_t;

  top_state_t state;

  // Configuration registers.
  logic [REG_W-1:0] x_raw_min;
  logic [REG_W-1:0] x_raw_max;
  logic [REG_W-1:0] y_raw_min;
  logic [REG_W-1:0] y_raw_max;
  logic [REG_W-1:0] pix_width;
  logic [REG_W-1:0] pix_height;
  logic [REG_W-1:0] move_threshold;

  // Tracking state and the pending event.
  logic                  was_down;
  logic [COORD_BITS-1:0] last_px;
  logic [COORD_BITS-1:0] last_py;
  logic [TIME_W-1:0]     stamp_q;
  logic [COORD_BITS-1:0] pend_x;
  logic [COORD_BITS-1:0] pend_y;
  logic                  pend_pressed;

  logic                  accept;
  logic                  lane_start;
  teg_lane_stat_t        stat_x;
  teg_lane_stat_t        stat_y;
  logic [COORD_BITS-1:0] map_x;
  logic [COORD_BITS-1:0] map_y;
  logic [CMP_W-1:0]      dx;
  logic [CMP_W-1:0]      dy;
  logic                  report;
  logic                  slot_free;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign lane_start   = accept && sample.touched;
  assign slot_free    = !evt_valid || !evt_stall;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_raw_min      <= X_RAW_MIN_RST;
      x_raw_max      <= X_RAW_MAX_RST;
      y_raw_min      <= Y_RAW_MIN_RST;
      y_raw_max      <= Y_RAW_MAX_RST;
      pix_width      <= PIX_WIDTH_RST;
      pix_height     <= PIX_HEIGHT_RST;
      move_threshold <= MOVE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_RAW_MIN:      x_raw_min      <= cfg_data;
        REG_X_RAW_MAX:      x_raw_max      <= cfg_data;
        REG_Y_RAW_MIN:      y_raw_min      <= cfg_data;
        REG_Y_RAW_MAX:      y_raw_max      <= cfg_data;
        REG_PIX_WIDTH:      pix_width      <= cfg_data;
        REG_PIX_HEIGHT:     pix_height     <= cfg_data;
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axis lanes.
  teg_axis_lane #(
    .COORD_BITS(COORD_BITS)
  ) u_lane_x (
    .clk  (clk),
    .rst  (rst),
    .start(lane_start),
    .raw  (sample.raw_x),
    .lo   (x_raw_min),
    .hi   (x_raw_max),
    .span (pix_width),
    .stat (stat_x),
    .coord(map_x)
  );

  teg_axis_lane #(
    .COORD_BITS(COORD_BITS)
  ) u_lane_y (
    .clk  (clk),
    .rst  (rst),
    .start(lane_start),
    .raw  (sample.raw_y),
    .lo   (y_raw_min),
    .hi   (y_raw_max),
    .span (pix_height),
    .stat (stat_y),
    .coord(map_y)
  );

  // Merge: a new touch or a move beyond the threshold on either axis.
  always_comb begin
    logic [CMP_W-1:0] ax;
    logic [CMP_W-1:0] bx;
    logic [CMP_W-1:0] ay;
    logic [CMP_W-1:0] by;
    ax = CMP_W'(map_x);
    bx = CMP_W'(last_px);
    ay = CMP_W'(map_y);
    by = CMP_W'(last_py);
    dx = (ax > bx) ? (ax - bx) : (bx - ax);
    dy = (ay > by) ? (ay - by) : (by - ay);
    report = !was_down ||
             (dx > CMP_W'(move_threshold)) ||
             (dy > CMP_W'(move_threshold));
  end

  // Sequencer, tracking state and event register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      was_down  <= 1'b0;
      last_px   <= '0;
      last_py   <= '0;
      evt_valid <= 1'b0;
    end else begin
      // The event register refills from the emit state and empties when taken.
      if (state == S_EMIT && slot_free) begin
        evt_valid <= 1'b1;
      end else if (evt_valid && !evt_stall) begin
        evt_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            stamp_q <= sample.time_ms;
            if (sample.touched) begin
              state <= S_MAP;
            end else if (was_down) begin
              was_down     <= 1'b0;
              pend_x       <= last_px;
              pend_y       <= last_py;
              pend_pressed <= 1'b0;
              state        <= S_EMIT;
            end
          end
        end
        S_MAP: begin
          if (stat_x.done) begin
            was_down <= 1'b1;
            if (report) begin
              last_px      <= map_x;
              last_py      <= map_y;
              pend_x       <= map_x;
              pend_y       <= map_y;
              pend_pressed <= 1'b1;
              state        <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            evt.pos_x     <= POS_W'(pend_x);
            evt.pos_y     <= POS_W'(pend_y);
            evt.pressed   <= pend_pressed;
            evt.stamp     <= stamp_q;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Both lanes run in lockstep.
  assert property (@(posedge clk) disable iff (rst) stat_x.done == stat_y.done)
    else $error("axis lanes finished in different cycles");

  // A tick is only taken while the lanes are free.
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |-> (!stat_x.busy && !stat_y.busy))
    else $error("tick accepted while a lane is busy");

  // A new event only appears out of the emit state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(evt_valid) |-> $past(state == S_EMIT))
    else $error("event raised outside the emit state");

  // The map state is only left once the lanes report done.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MAP && !stat_x.done) |=> (state == S_MAP))
    else $error("map state left before lanes finished");

endmodule
